// ===== rtl/core/quadrature_tone_generator_defines.svh =====
// assertion macros shared by the tone generator rtl
`ifndef QUADRATURE_TONE_GENERATOR_DEFINES_SVH
`define QUADRATURE_TONE_GENERATOR_DEFINES_SVH

// immediate-cycle check, quiet while reset is asserted
`define QTG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// check that a condition holds in the cycle after a trigger
`define QTG_ASSERT_NEXT(name, pre, post, msg) \
  `QTG_ASSERT(name, (pre) |=> (post), msg)

`endif

// ===== rtl/core/qtg_pkg.sv =====
// shared types and constants of the quadrature tone generator
package qtg_pkg;

  // fixed-point constants, q1.30
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [30:0] PIO2_Q30 = 31'd1686629713;

  // series divisors, horner order
  localparam int unsigned SIN_TERMS = 6;
  localparam int unsigned COS_TERMS = 5;
  localparam int unsigned SIN_DIV [SIN_TERMS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_TERMS] = '{132, 90, 56, 30, 12};

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_AMPLITUDE    = 2'd1,
    REG_SAMPLE_COUNT = 2'd2,
    REG_UNUSED       = 2'd3
  } qtg_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } qtg_quad_e;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [15:0] amplitude_scale;
    logic [24:0] record_len;
  } qtg_cfg_t;

  // one classified item: 32-bit phase of the sample and its last flag
  typedef struct packed {
    logic [31:0] phase;
    logic        last;
  } qtg_item_t;

  // sideband that travels beside the trig pipeline
  typedef struct packed {
    qtg_quad_e   quad;
    logic        last;
    logic [30:0] t;
    logic [31:0] t2;
  } qtg_side_t;

endpackage

// ===== rtl/core/qtg_front.sv =====
// front end: accepts items, runs the phase accumulator and sample index
module qtg_front #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qtg_pkg::qtg_cfg_t  cfg_i,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic               restart_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output qtg_pkg::qtg_item_t item_o
);
  import qtg_pkg::*;

  `include "quadrature_tone_generator_defines.svh"

  localparam int unsigned CW = (COUNT_BITS > 25) ? COUNT_BITS : 25;

  logic [PHASE_BITS-1:0]    acc_q, acc_d;
  logic [COUNT_BITS-1:0]    idx_q, idx_d;
  logic [PHASE_BITS-1:0]    base_ph;
  logic [COUNT_BITS-1:0]    base_idx;
  logic [PHASE_BITS+31:0]   ph_wide;
  logic [CW-1:0]            target;
  logic                     last;
  logic                     accept;

  assign s_ready_o = !fifo_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign push_o    = accept;

  // restart clears phase and index before this sample
  assign base_ph  = restart_i ? '0 : acc_q;
  assign base_idx = restart_i ? '0 : idx_q;

  // top 32 phase bits, zero filled when the accumulator is narrower
  assign ph_wide = {base_ph, 32'b0};
  assign target  = CW'(cfg_i.record_len - 25'd1);
  assign last    = (CW'(base_idx) == target);

  assign item_o.phase = ph_wide[PHASE_BITS+31 -: 32];
  assign item_o.last  = last;

  assign acc_d = base_ph + PHASE_BITS'(cfg_i.phase_step);
  assign idx_d = last ? '0 : base_idx + COUNT_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      idx_q <= '0;
    end else if (accept) begin
      acc_q <= acc_d;
      idx_q <= idx_d;
    end
  end

  `QTG_ASSERT_NEXT(a_restart_idx, accept && restart_i,
                   idx_q == '0 || idx_q == COUNT_BITS'(1), "index after restart out of range")

endmodule

// ===== rtl/core/qtg_fifo.sv =====
// short item queue between front and back
module qtg_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  qtg_pkg::qtg_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output qtg_pkg::qtg_item_t item_o
);
  import qtg_pkg::*;

  `include "quadrature_tone_generator_defines.svh"

  qtg_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  assign full_o  = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (FIFO_AW + 1)'(1);
        2'b01:   count_q <= count_q - (FIFO_AW + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `QTG_ASSERT(a_no_underflow, pop_i |-> count_q != '0, "queue popped while empty")
  `QTG_ASSERT(a_no_overflow, push_i |-> !full_o, "queue pushed while full")

endmodule

// ===== rtl/core/qtg_horner.sv =====
// one horner step: one - ((t2 * acc) >> 30) / D, three register stages
module qtg_horner #(
  parameter int unsigned D = 6
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] t2_i,
  input  logic [30:0] acc_i,
  output logic [30:0] acc_o
);
  import qtg_pkg::*;

  // floor(2^33 / D) keeps the quotient estimate within one of exact
  localparam logic [31:0] RECIP = 32'((64'd1 << 33) / D);

  logic [62:0] prod_a;
  logic [63:0] prod_b;
  logic [39:0] qd;
  logic [39:0] rem;
  logic [30:0] quo;
  logic [31:0] p_q, p2_q;
  logic [30:0] qe_q;
  logic [30:0] acc_q;

  assign prod_a = 63'(t2_i) * 63'(acc_i);
  assign prod_b = 64'(p_q) * 64'(RECIP);

  // remainder check corrects the estimate by at most one
  assign qd  = 40'(qe_q) * 40'(D);
  assign rem = 40'(p2_q) - qd;
  assign quo = qe_q + 31'(rem >= 40'(D));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= prod_a[61:30];
      p2_q  <= p_q;
      qe_q  <= prod_b[63:33];
      acc_q <= ONE_Q30 - quo;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/qtg_back.sv =====
// back end: sine/cosine pipeline, quadrant fold, scaling and output stage
module qtg_back #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qtg_pkg::qtg_cfg_t   cfg_i,
  input  logic                in_valid_i,
  input  qtg_pkg::qtg_item_t  in_item_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OUT_BITS-1:0] i_o,
  output logic [OUT_BITS-1:0] q_o,
  output logic                last_o
);
  import qtg_pkg::*;

  `include "quadrature_tone_generator_defines.svh"

  localparam int unsigned NSTG = 24;

  logic              adv;
  logic [NSTG:1]     vld_q;
  qtg_side_t         sb_q [1:NSTG];

  logic [60:0]       t_prod;
  logic [61:0]       t2_prod;
  logic [30:0]       sin_acc [SIN_TERMS+1];
  logic [30:0]       cos_acc [COS_TERMS+1];
  logic [61:0]       s_prod;
  logic [62:0]       c_prod;
  logic [31:0]       s_q;
  logic [31:0]       cpr_q;
  logic signed [32:0] c19_q, c20_q, c21_q;
  logic signed [32:0] s33;
  logic signed [33:0] iv, qv;
  logic              i_neg_q, q_neg_q, i_neg2_q, q_neg2_q;
  logic [31:0]       i_mag_q, q_mag_q;
  logic [47:0]       i_prod_q, q_prod_q;
  logic [OUT_BITS-1:0] i_out_q, q_out_q;

  // amplitude * v / 2^31, ties to even, saturated to OUT_BITS
  function automatic logic [OUT_BITS-1:0] rnd_sat(input logic [47:0] prod,
                                                  input logic neg);
    logic [16:0] qt;
    logic [30:0] r;
    logic [24:0] ext;
    logic [24:0] lim;
    logic [24:0] res;
    qt  = prod[47:31];
    r   = prod[30:0];
    lim = 25'd1 << (OUT_BITS - 1);
    ext = 25'(qt);
    if (r > 31'h4000_0000 || (r == 31'h4000_0000 && qt[0])) begin
      ext = ext + 25'd1;
    end
    if (ext > lim) begin
      ext = lim;
    end
    if (neg) begin
      res = ~ext + 25'd1;
    end else if (ext >= lim) begin
      res = lim - 25'd1;
    end else begin
      res = ext;
    end
    return res[OUT_BITS-1:0];
  endfunction

  // whole pipeline moves together whenever the output stage can move
  assign adv   = !vld_q[NSTG] || m_ready_i;
  assign pop_o = adv && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-1:1], in_valid_i};
    end
  end

  // angle in radians and its square
  assign t_prod  = 61'(in_item_i.phase[29:0]) * 61'(PIO2_Q30);
  assign t2_prod = 62'(sb_q[1].t) * 62'(sb_q[1].t);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[1].quad <= qtg_quad_e'(in_item_i.phase[31:30]);
      sb_q[1].last <= in_item_i.last;
      sb_q[1].t    <= t_prod[60:30];
      sb_q[1].t2   <= '0;
      sb_q[2].quad <= sb_q[1].quad;
      sb_q[2].last <= sb_q[1].last;
      sb_q[2].t    <= sb_q[1].t;
      sb_q[2].t2   <= t2_prod[61:30];
      for (int k = 3; k <= NSTG; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // sine series, stages 3 to 20
  assign sin_acc[0] = ONE_Q30;
  for (genvar g = 0; g < SIN_TERMS; g++) begin : g_sin
    qtg_horner #(.D(SIN_DIV[g])) u_horner (
      .clk_i (clk_i),
      .en_i  (adv),
      .t2_i  (sb_q[2+3*g].t2),
      .acc_i (sin_acc[g]),
      .acc_o (sin_acc[g+1])
    );
  end

  // cosine series, stages 3 to 17
  assign cos_acc[0] = ONE_Q30;
  for (genvar g = 0; g < COS_TERMS; g++) begin : g_cos
    qtg_horner #(.D(COS_DIV[g])) u_horner (
      .clk_i (clk_i),
      .en_i  (adv),
      .t2_i  (sb_q[2+3*g].t2),
      .acc_i (cos_acc[g]),
      .acc_o (cos_acc[g+1])
    );
  end

  assign s_prod = 62'(sb_q[20].t) * 62'(sin_acc[SIN_TERMS]);
  assign c_prod = 63'(sb_q[17].t2) * 63'(cos_acc[COS_TERMS]);
  assign s33    = $signed({1'b0, s_q});

  // quadrant fold
  always_comb begin
    case (sb_q[21].quad)
      QUAD_0: begin
        iv = 34'(c21_q);
        qv = 34'(s33);
      end
      QUAD_1: begin
        iv = -34'(s33);
        qv = 34'(c21_q);
      end
      QUAD_2: begin
        iv = -34'(c21_q);
        qv = -34'(s33);
      end
      default: begin
        iv = 34'(s33);
        qv = -34'(c21_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cpr_q    <= c_prod[61:30];
      c19_q    <= $signed({2'b0, ONE_Q30}) - $signed({2'b0, cpr_q[31:1]});
      c20_q    <= c19_q;
      c21_q    <= c20_q;
      s_q      <= s_prod[61:30];
      i_neg_q  <= iv[33];
      q_neg_q  <= qv[33];
      i_mag_q  <= iv[33] ? 32'(-iv) : 32'(iv);
      q_mag_q  <= qv[33] ? 32'(-qv) : 32'(qv);
      i_neg2_q <= i_neg_q;
      q_neg2_q <= q_neg_q;
      i_prod_q <= 48'(i_mag_q) * 48'(cfg_i.amplitude_scale);
      q_prod_q <= 48'(q_mag_q) * 48'(cfg_i.amplitude_scale);
      i_out_q  <= rnd_sat(i_prod_q, i_neg2_q);
      q_out_q  <= rnd_sat(q_prod_q, q_neg2_q);
    end
  end

  assign m_valid_o = vld_q[NSTG];
  assign i_o       = i_out_q;
  assign q_o       = q_out_q;
  assign last_o    = sb_q[NSTG].last;

  `QTG_ASSERT_NEXT(a_stall_freeze, vld_q[NSTG] && !m_ready_i, $stable(vld_q),
                   "pipeline moved while output stalled")

endmodule

// ===== rtl/core/quadrature_tone_generator.sv =====
// top level of the quadrature tone generator (nco with i/q output)
//
// Quadrature oscillator: every accepted input item yields one complex sample
// on the output stream, i = round(A/2 * cos(phase)) and q = round(A/2 *
// sin(phase)), with A the amplitude_scale register, rounded to nearest (ties
// to even) and saturated to signed OUT_BITS. The phase accumulator is an
// exact binary fraction of a turn that advances by phase_step after each
// sample; bit 0 of the input item (restart) zeroes phase and sample index
// before that item's sample. tlast marks sample number record_len - 1,
// after which the index returns to zero while the phase keeps running.
// Throughput is one sample per clock while the output is not stalled: the front
// end updates the accumulator in the cycle an item is taken, and every back-end
// stage is fully pipelined. An accepted item passes through the four-entry
// queue and then the 24 back-end stages, a depth set by the sine series (six
// horner steps of three stages each: multiply, reciprocal multiply,
// remainder correction). A stalled output freezes the back end; the queue
// lets the input keep flowing until it fills.
// Registers (APB, 32-bit data, byte address 4*i):
//   0x0 phase_step      tone frequency / sample rate in units of 2^-32 turn
//   0x4 amplitude_scale output peak in half-lsb units, reset 32767
//   0x8 record_len      samples per recording (25 bits), reset 1048576
// Write registers only while the block is idle.
module quadrature_tone_generator #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned OUT_BITS   = 16,
  parameter int unsigned COUNT_BITS = 24,
  localparam int unsigned TDATA_W   = ((2 * OUT_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [0] restart, [7:1] zero
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // i_sample, q_sample, zero fill
  output logic               m_axis_tlast
);
  import qtg_pkg::*;

  // configuration registers
  logic [31:0] phase_step_q;
  logic [15:0] amplitude_q;
  logic [24:0] record_len_q;
  logic        cfg_wr;
  qtg_reg_e    reg_sel;
  qtg_cfg_t    cfg;

  // front to queue to back
  logic        push;
  logic        fifo_full;
  logic        fifo_valid;
  logic        pop;
  qtg_item_t   front_item;
  qtg_item_t   back_item;

  logic [OUT_BITS-1:0] i_sample;
  logic [OUT_BITS-1:0] q_sample;

  // register file; address bits below the word offset are ignored
  assign pready  = 1'b1;
  assign reg_sel = qtg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= 32'h2000_0000;
      amplitude_q  <= 16'd32767;
      record_len_q <= 25'd1048576;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PHASE_STEP:   phase_step_q <= pwdata;
        REG_AMPLITUDE:    amplitude_q  <= pwdata[15:0];
        REG_SAMPLE_COUNT: record_len_q <= pwdata[24:0];
        default: ;        // unmapped word, write ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PHASE_STEP:   prdata = phase_step_q;
      REG_AMPLITUDE:    prdata = 32'(amplitude_q);
      REG_SAMPLE_COUNT: prdata = 32'(record_len_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg.phase_step      = phase_step_q;
  assign cfg.amplitude_scale = amplitude_q;
  assign cfg.record_len      = record_len_q;

  // front end: phase accumulator, sample index and last-sample flag
  qtg_front #(
    .PHASE_BITS (PHASE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .restart_i   (s_axis_tdata[0]),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  // decouples input acceptance from output backpressure
  qtg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .item_o  (back_item)
  );

  // back end: trig series, quadrant fold, scale, round and saturate
  qtg_back #(
    .OUT_BITS (OUT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (fifo_valid),
    .in_item_i  (back_item),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .i_o        (i_sample),
    .q_o        (q_sample),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'({q_sample, i_sample});

endmodule
